// ----- rtl/frontlight_color_mixer_defines.svh -----
// Assertion macros shared by the frontlight color mixer RTL.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef FRONTLIGHT_COLOR_MIXER_DEFINES_SVH
`define FRONTLIGHT_COLOR_MIXER_DEFINES_SVH

// Check a condition in the same cycle as its trigger.
`define FCM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("frontlight color mixer check failed");

// Check a condition in the cycle after its trigger.
`define FCM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("frontlight color mixer check failed");

`endif

// ----- rtl/fcm_pkg.sv -----
// Shared types, widths and constants of the frontlight color mixer.
// No dependencies; fcm_if, fcm_front, fcm_queue, fcm_back and the top level refer to it by scope.
`timescale 1ns / 1ps

package fcm_pkg;

  localparam int unsigned LEVEL_W    = 8;
  localparam int unsigned REQ_W      = 16;
  localparam int unsigned TEMP_W     = 9;   // signed temperature after inversion
  localparam int unsigned PROD_W     = 17;  // level times temperature span
  localparam int unsigned GAIN_W     = 19;  // fourth power of a channel gain
  localparam int unsigned RAD_W      = GAIN_W + PROD_W;
  localparam int unsigned ROOT2_W    = RAD_W / 2;
  localparam int unsigned ROOT4_W    = RAD_W / 4;
  localparam int unsigned CFG_ADDR_W = 5;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned QUEUE_DEPTH_DEF = 4;

  localparam logic [GAIN_W-1:0]  W_SCALE4  = 19'd390625;  // 25^4
  localparam logic [GAIN_W-1:0]  R_SCALE4  = 19'd331776;  // 24^4
  localparam logic [ROOT4_W-1:0] W_BIAS    = 9'd25;
  localparam logic [ROOT4_W-1:0] G_BIAS    = 9'd65;
  localparam logic [LEVEL_W-1:0] LEVEL_CAP = 8'd255;

  // Light modes.
  localparam logic [1:0] MODE_OFF   = 2'd0;
  localparam logic [1:0] MODE_PLAIN = 2'd1;
  localparam logic [1:0] MODE_MIXER = 2'd2;
  localparam logic [1:0] MODE_RGB   = 2'd3;

  // Channels each mode may write.
  localparam logic [3:0] MASK_MIXER = 4'b1001;
  localparam logic [3:0] MASK_RGB   = 4'b0111;

  typedef enum logic [2:0] {
    REG_LIGHT_MODE      = 3'd0,
    REG_TEMP_INVERTED   = 3'd1,
    REG_CHANNEL_PRESENT = 3'd2,
    REG_LEVEL_MIN       = 3'd3,
    REG_LEVEL_MAX       = 3'd4,
    REG_TEMP_MIN        = 3'd5,
    REG_TEMP_MAX        = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic [1:0]         light_mode;
    logic               temp_inverted;
    logic [3:0]         channel_present;
    logic [LEVEL_W-1:0] level_min;
    logic [LEVEL_W-1:0] level_max;
    logic [LEVEL_W-1:0] temp_min;
    logic [LEVEL_W-1:0] temp_max;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    light_mode:      2'd0,
    temp_inverted:   1'b0,
    channel_present: 4'd0,
    level_min:       8'd0,
    level_max:       8'd100,
    temp_min:        8'd0,
    temp_max:        8'd10
  };

  // Classified request: clamped level and temperature after inversion.
  typedef struct packed {
    logic [LEVEL_W-1:0]        level;
    logic signed [TEMP_W-1:0]  temp;
  } item_t;

  typedef struct packed {
    logic push;
    logic pop;
    logic full;
    logic empty;
  } q_status_t;

endpackage

// ----- rtl/fcm_if.sv -----
// Valid/ready channel interfaces for the request and result sides.
// Depends on fcm_pkg for field widths.
`timescale 1ns / 1ps

interface fcm_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [fcm_pkg::REQ_W-1:0]    level_request;
  logic signed [fcm_pkg::REQ_W-1:0]    temp_request;

  modport source (output valid, output level_request, output temp_request, input ready);
  modport sink   (input valid, input level_request, input temp_request, output ready);
endinterface

interface fcm_out_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    target;
  logic [fcm_pkg::LEVEL_W-1:0]   plain_level;
  logic [fcm_pkg::LEVEL_W-1:0]   white_level;
  logic [fcm_pkg::LEVEL_W-1:0]   red_level;
  logic [fcm_pkg::LEVEL_W-1:0]   green_level;
  logic [fcm_pkg::LEVEL_W-1:0]   mixer_level;
  logic [3:0]                    write_mask;
  logic [2:0]                    power_mask;

  modport source (output valid, output target, output plain_level, output white_level,
                  output red_level, output green_level, output mixer_level,
                  output write_mask, output power_mask, input ready);
  modport sink   (input valid, input target, input plain_level, input white_level,
                  input red_level, input green_level, input mixer_level,
                  input write_mask, input power_mask, output ready);
endinterface

// ----- rtl/frontlight_color_mixer.sv -----
// Frontlight color mixer top level: config registers, front end, queue, back end.
// Throughput: one request per cycle unless the result side stalls; the two
//   27-stage root pipelines take one result bit per stage (18 stages for the
//   first square root, 9 for the second).
// Reset: synchronous, active low; config returns to defaults, all valids clear.
`timescale 1ns / 1ps
`include "frontlight_color_mixer_defines.svh"

module frontlight_color_mixer #(
  parameter int unsigned QUEUE_DEPTH = fcm_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  fcm_in_if.sink                          in_ch,
  fcm_out_if.source                       out_ch,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [fcm_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [fcm_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [fcm_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                            pready
);

  localparam int unsigned DW = fcm_pkg::CFG_DATA_W;

  fcm_pkg::cfg_t      cfg_r;
  fcm_pkg::cfg_reg_t  cfg_sel;
  logic               cfg_wr;
  fcm_pkg::q_status_t qs;
  logic               push_req;
  fcm_pkg::item_t     push_item;
  logic               pop_req;
  fcm_pkg::item_t     head_item;

  // ---------------------------------------------------------------------------
  // Config port. Always ready; write on the access phase. Registers sit on
  // word addresses, so drop the byte offset and decode the word index.
  // Writes past the last register fall into the default arm and are dropped.
  // ---------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_sel = fcm_pkg::cfg_reg_t'(paddr[fcm_pkg::CFG_ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= fcm_pkg::CFG_RESET;
    end else if (cfg_wr) begin
      case (cfg_sel)
        fcm_pkg::REG_LIGHT_MODE:      cfg_r.light_mode      <= pwdata[1:0];
        fcm_pkg::REG_TEMP_INVERTED:   cfg_r.temp_inverted   <= pwdata[0];
        fcm_pkg::REG_CHANNEL_PRESENT: cfg_r.channel_present <= pwdata[3:0];
        fcm_pkg::REG_LEVEL_MIN:       cfg_r.level_min       <= pwdata[7:0];
        fcm_pkg::REG_LEVEL_MAX:       cfg_r.level_max       <= pwdata[7:0];
        fcm_pkg::REG_TEMP_MIN:        cfg_r.temp_min        <= pwdata[7:0];
        fcm_pkg::REG_TEMP_MAX:        cfg_r.temp_max        <= pwdata[7:0];
        default: begin
        end
      endcase
    end
  end

  // Read back the selected register, zero-extended.
  always_comb begin
    case (cfg_sel)
      fcm_pkg::REG_LIGHT_MODE:      prdata = DW'(cfg_r.light_mode);
      fcm_pkg::REG_TEMP_INVERTED:   prdata = DW'(cfg_r.temp_inverted);
      fcm_pkg::REG_CHANNEL_PRESENT: prdata = DW'(cfg_r.channel_present);
      fcm_pkg::REG_LEVEL_MIN:       prdata = DW'(cfg_r.level_min);
      fcm_pkg::REG_LEVEL_MAX:       prdata = DW'(cfg_r.level_max);
      fcm_pkg::REG_TEMP_MIN:        prdata = DW'(cfg_r.temp_min);
      fcm_pkg::REG_TEMP_MAX:        prdata = DW'(cfg_r.temp_max);
      default:                      prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Front end: take one request transfer per cycle, clamp both fields, apply
  // inversion and hold the classified item until the queue has room.
  // ---------------------------------------------------------------------------
  fcm_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_ch     (in_ch),
    .qs        (qs),
    .push_req  (push_req),
    .push_item (push_item)
  );

  // ---------------------------------------------------------------------------
  // Queue: decouple the front end from back-end stalls so a held result does
  // not block new requests until the queue fills.
  // ---------------------------------------------------------------------------
  fcm_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_req  (push_req),
    .push_item (push_item),
    .pop_req   (pop_req),
    .head_item (head_item),
    .status    (qs)
  );

  // ---------------------------------------------------------------------------
  // Back end: form products, scale by gain^4, take two square roots in a row
  // for each of white and red, then saturate, mask and register the result.
  // The pipeline advances as one whenever the result register is free or its
  // result transfers; bubbles ride along and are dropped at the output.
  // ---------------------------------------------------------------------------
  fcm_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .qs        (qs),
    .head_item (head_item),
    .pop_req   (pop_req),
    .out_ch    (out_ch)
  );

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  // Hold the queue while a result waits: a stalled output must not drain it.
  `FCM_ASSERT_NOW(a_stall_no_pop, out_ch.valid && !out_ch.ready, !qs.pop)
  // An item written into the queue is there on the next cycle.
  `FCM_ASSERT_NEXT(a_push_not_empty, qs.push, !qs.empty)
  // Power flags only exist in rgb mode.
  `FCM_ASSERT_NOW(a_power_rgb_only, out_ch.valid && (out_ch.target != fcm_pkg::MODE_RGB), out_ch.power_mask == '0)
  // With the frontlight off nothing is written.
  `FCM_ASSERT_NOW(a_off_writes_nothing, out_ch.valid && (out_ch.target == fcm_pkg::MODE_OFF), (out_ch.write_mask == '0) && (out_ch.plain_level == '0))

endmodule

// ----- rtl/fcm_front.sv -----
// Front end: accepts requests, clamps level and temperature, applies inversion.
// Depends on fcm_pkg and fcm_in_if; feeds fcm_queue.
`timescale 1ns / 1ps

module fcm_front (
  input  logic               clk,
  input  logic               rst_n,
  input  fcm_pkg::cfg_t      cfg,
  fcm_in_if.sink             in_ch,
  input  fcm_pkg::q_status_t qs,
  output logic               push_req,
  output fcm_pkg::item_t     push_item
);

  logic                                front_v_r, front_v_nxt;
  fcm_pkg::item_t                      item_r, item_nxt;
  logic                                take;
  logic [fcm_pkg::LEVEL_W-1:0]         level_c;
  logic [fcm_pkg::LEVEL_W-1:0]         temp_c;
  logic signed [fcm_pkg::TEMP_W-1:0]   temp_s;

  // Upper bound first, then lower bound: the lower bound wins when crossed.
  function automatic logic [fcm_pkg::LEVEL_W-1:0] clamp_req(
    input logic signed [fcm_pkg::REQ_W-1:0] v,
    input logic [fcm_pkg::LEVEL_W-1:0]      lo,
    input logic [fcm_pkg::LEVEL_W-1:0]      hi
  );
    logic signed [fcm_pkg::REQ_W-1:0] lo_s;
    logic signed [fcm_pkg::REQ_W-1:0] hi_s;
    logic signed [fcm_pkg::REQ_W-1:0] c;
    lo_s = $signed({{(fcm_pkg::REQ_W-fcm_pkg::LEVEL_W){1'b0}}, lo});
    hi_s = $signed({{(fcm_pkg::REQ_W-fcm_pkg::LEVEL_W){1'b0}}, hi});
    c = v;
    if (c > hi_s) c = hi_s;
    if (c < lo_s) c = lo_s;
    return c[fcm_pkg::LEVEL_W-1:0];
  endfunction

  assign in_ch.ready = !front_v_r || !qs.full;
  assign take        = in_ch.valid && in_ch.ready;
  assign push_req    = front_v_r;
  assign push_item   = item_r;

  always_comb begin
    level_c = clamp_req(in_ch.level_request, cfg.level_min, cfg.level_max);
    temp_c  = clamp_req(in_ch.temp_request, cfg.temp_min, cfg.temp_max);
    if (cfg.temp_inverted) begin
      temp_s = $signed({1'b0, cfg.temp_max}) - $signed({1'b0, temp_c});
    end else begin
      temp_s = $signed({1'b0, temp_c});
    end

    front_v_nxt = front_v_r;
    item_nxt    = item_r;
    if (qs.push) front_v_nxt = 1'b0;
    if (take) begin
      front_v_nxt    = 1'b1;
      item_nxt.level = level_c;
      item_nxt.temp  = temp_s;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_v_r <= 1'b0;
    end else begin
      front_v_r <= front_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
  end

endmodule

// ----- rtl/fcm_queue.sv -----
// Small register FIFO between the front end and the back end.
// Depends on fcm_pkg.
`timescale 1ns / 1ps

module fcm_queue #(
  parameter int unsigned DEPTH = fcm_pkg::QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push_req,
  input  fcm_pkg::item_t     push_item,
  input  logic               pop_req,
  output fcm_pkg::item_t     head_item,
  output fcm_pkg::q_status_t status
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  fcm_pkg::item_t   mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             full, empty, push, pop;

  assign full  = (count_r == FULL_CNT);
  assign empty = (count_r == '0);
  assign push  = push_req && !full;
  assign pop   = pop_req && !empty;

  assign head_item = mem_r[rd_ptr_r];
  assign status    = '{push: push, pop: pop, full: full, empty: empty};

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    if (pop)  rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    count_nxt = count_r + CNT_W'(push) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_item;
  end

endmodule

// ----- rtl/fcm_isqrt.sv -----
// Pipelined integer square root, one result bit per stage.
// Depends on nothing; stalls as a whole on en.
`timescale 1ns / 1ps

module fcm_isqrt #(
  parameter int unsigned IN_W = 36
) (
  input  logic              clk,
  input  logic              en,
  input  logic [IN_W-1:0]   radicand,
  output logic [IN_W/2-1:0] root
);

  localparam int unsigned STAGES = IN_W / 2;
  localparam int unsigned REM_W  = STAGES + 2;

  logic [IN_W-1:0]   x_r    [STAGES-1];
  logic [REM_W-1:0]  rem_r  [STAGES-1];
  logic [STAGES-1:0] root_r [STAGES];

  for (genvar k = 0; k < STAGES; k++) begin : g_stage
    logic [IN_W-1:0]   x_in;
    logic [REM_W-1:0]  rem_in;
    logic [STAGES-1:0] root_in;
    logic [REM_W-1:0]  rem_sh;
    logic [REM_W-1:0]  trial;
    logic              fits;

    if (k == 0) begin : g_first
      assign x_in    = radicand;
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign x_in    = x_r[k-1];
      assign rem_in  = rem_r[k-1];
      assign root_in = root_r[k-1];
    end

    // Bring down the next two radicand bits and try root*4+1.
    assign rem_sh = {rem_in[REM_W-3:0], x_in[IN_W-1 -: 2]};
    assign trial  = {root_in, 2'b01};
    assign fits   = (rem_sh >= trial);

    always_ff @(posedge clk) begin
      if (en) begin
        root_r[k] <= {root_in[STAGES-2:0], fits};
      end
    end

    if (k < STAGES - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          x_r[k]   <= {x_in[IN_W-3:0], 2'b00};
          rem_r[k] <= fits ? (rem_sh - trial) : rem_sh;
        end
      end
    end
  end

  assign root = root_r[STAGES-1];

endmodule

// ----- rtl/fcm_back.sv -----
// Back end: products, gain scaling, two fourth-root pipelines and result register.
// Depends on fcm_pkg, fcm_isqrt and fcm_out_if; pops fcm_queue.
`timescale 1ns / 1ps

module fcm_back (
  input  logic               clk,
  input  logic               rst_n,
  input  fcm_pkg::cfg_t      cfg,
  input  fcm_pkg::q_status_t qs,
  input  fcm_pkg::item_t     head_item,
  output logic               pop_req,
  fcm_out_if.source          out_ch
);

  localparam int unsigned LEVEL_W = fcm_pkg::LEVEL_W;
  localparam int unsigned TEMP_W  = fcm_pkg::TEMP_W;
  localparam int unsigned PROD_W  = fcm_pkg::PROD_W;
  localparam int unsigned RAD_W   = fcm_pkg::RAD_W;
  localparam int unsigned ROOT2_W = fcm_pkg::ROOT2_W;
  localparam int unsigned ROOT4_W = fcm_pkg::ROOT4_W;
  // Product stage, gain stage, then both root pipelines.
  localparam int unsigned LINE_LEN = 2 + ROOT2_W + ROOT4_W;
  localparam int unsigned LAST     = LINE_LEN - 1;

  typedef struct packed {
    logic [1:0]         target;
    logic [LEVEL_W-1:0] plain_level;
    logic [LEVEL_W-1:0] white_level;
    logic [LEVEL_W-1:0] red_level;
    logic [LEVEL_W-1:0] green_level;
    logic [LEVEL_W-1:0] mixer_level;
    logic [3:0]         write_mask;
    logic [2:0]         power_mask;
  } res_t;

  logic                         en;
  logic                         line_v_r [LINE_LEN];
  fcm_pkg::item_t               line_r   [LINE_LEN];

  logic signed [TEMP_W+1:0]     wdiff;
  logic [TEMP_W:0]              wfac;
  logic [LEVEL_W-1:0]           rfac;
  logic [LEVEL_W+TEMP_W:0]      pw_full;
  logic [2*LEVEL_W-1:0]         pr_full;
  logic [PROD_W-1:0]            pw_r, pw_nxt;
  logic [PROD_W-1:0]            pr_r, pr_nxt;
  logic [RAD_W-1:0]             gw_r, gw_nxt;
  logic [RAD_W-1:0]             gr_r, gr_nxt;
  logic [ROOT2_W-1:0]           w_sq2, r_sq2;
  logic [ROOT4_W-1:0]           w_root, r_root;

  fcm_pkg::item_t               sb;
  logic                         b_pos, t_pos;
  logic                         out_v_r, out_v_nxt;
  res_t                         res_r, res_nxt;

  function automatic logic [LEVEL_W-1:0] sat8(input logic signed [ROOT4_W:0] v);
    logic signed [ROOT4_W:0] cap;
    cap = $signed({{(ROOT4_W+1-LEVEL_W){1'b0}}, fcm_pkg::LEVEL_CAP});
    if (v < 0) return '0;
    if (v > cap) return fcm_pkg::LEVEL_CAP;
    return v[LEVEL_W-1:0];
  endfunction

  // The whole back end advances together whenever the result register frees up.
  assign en      = !out_v_r || out_ch.ready;
  assign pop_req = en;

  // Product stage: b * (temp_max - t) for white, b * t for red, negatives as zero.
  always_comb begin
    wdiff   = $signed({3'b000, cfg.temp_max})
            - $signed({{2{head_item.temp[TEMP_W-1]}}, head_item.temp});
    wfac    = wdiff[TEMP_W+1] ? '0 : wdiff[TEMP_W:0];
    rfac    = (!head_item.temp[TEMP_W-1] && (head_item.temp != '0))
            ? head_item.temp[LEVEL_W-1:0] : '0;
    pw_full = head_item.level * wfac;
    pr_full = head_item.level * rfac;
    pw_nxt  = pw_full[PROD_W-1:0];
    pr_nxt  = PROD_W'(pr_full);
  end

  // Gain stage: scale by gain^4 so a plain fourth root gives floor(gain*p^0.25).
  assign gw_nxt = fcm_pkg::W_SCALE4 * pw_r;
  assign gr_nxt = fcm_pkg::R_SCALE4 * pr_r;

  always_ff @(posedge clk) begin
    if (en) begin
      pw_r <= pw_nxt;
      pr_r <= pr_nxt;
      gw_r <= gw_nxt;
      gr_r <= gr_nxt;
      line_r[0] <= head_item;
      for (int k = 1; k < LINE_LEN; k++) begin
        line_r[k] <= line_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < LINE_LEN; k++) begin
        line_v_r[k] <= 1'b0;
      end
    end else if (en) begin
      line_v_r[0] <= qs.pop;
      for (int k = 1; k < LINE_LEN; k++) begin
        line_v_r[k] <= line_v_r[k-1];
      end
    end
  end

  // Fourth root as two square roots in a row.
  fcm_isqrt #(.IN_W(RAD_W))   u_w_sq2  (.clk(clk), .en(en), .radicand(gw_r),  .root(w_sq2));
  fcm_isqrt #(.IN_W(ROOT2_W)) u_w_root (.clk(clk), .en(en), .radicand(w_sq2), .root(w_root));
  fcm_isqrt #(.IN_W(RAD_W))   u_r_sq2  (.clk(clk), .en(en), .radicand(gr_r),  .root(r_sq2));
  fcm_isqrt #(.IN_W(ROOT2_W)) u_r_root (.clk(clk), .en(en), .radicand(r_sq2), .root(r_root));

  // Result stage.
  always_comb begin
    sb    = line_r[LAST];
    b_pos = (sb.level != '0);
    t_pos = !sb.temp[TEMP_W-1] && (sb.temp != '0);

    res_nxt        = '0;
    res_nxt.target = cfg.light_mode;
    case (cfg.light_mode)
      fcm_pkg::MODE_OFF: begin
        res_nxt.target = fcm_pkg::MODE_OFF;
      end
      fcm_pkg::MODE_PLAIN: begin
        res_nxt.plain_level = sb.level;
      end
      fcm_pkg::MODE_MIXER: begin
        res_nxt.white_level = sb.level;
        res_nxt.mixer_level = sb.temp[TEMP_W-1] ? '0 : sb.temp[LEVEL_W-1:0];
        res_nxt.write_mask  = cfg.channel_present & fcm_pkg::MASK_MIXER;
      end
      fcm_pkg::MODE_RGB: begin
        if (b_pos) begin
          res_nxt.white_level = sat8($signed({1'b0, w_root})
                                   - $signed({1'b0, fcm_pkg::W_BIAS}));
        end
        if (t_pos) begin
          res_nxt.red_level   = sat8($signed({1'b0, r_root}));
          res_nxt.green_level = sat8($signed({1'b0, r_root})
                                   - $signed({1'b0, fcm_pkg::G_BIAS}));
        end
        res_nxt.write_mask = cfg.channel_present & fcm_pkg::MASK_RGB;
        res_nxt.power_mask = {res_nxt.green_level != '0,
                              res_nxt.red_level != '0,
                              res_nxt.white_level != '0};
      end
      default: begin
        res_nxt = '0;
      end
    endcase

    out_v_nxt = en ? line_v_r[LAST] : out_v_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) res_r <= res_nxt;
  end

  assign out_ch.valid       = out_v_r;
  assign out_ch.target      = res_r.target;
  assign out_ch.plain_level = res_r.plain_level;
  assign out_ch.white_level = res_r.white_level;
  assign out_ch.red_level   = res_r.red_level;
  assign out_ch.green_level = res_r.green_level;
  assign out_ch.mixer_level = res_r.mixer_level;
  assign out_ch.write_mask  = res_r.write_mask;
  assign out_ch.power_mask  = res_r.power_mask;

endmodule

// ----- sim/frontlight_color_mixer_tb.sv -----
// Self-checking testbench for the frontlight color mixer: directed and random requests,
// register access over the config port, and per-field checks of every result.
// Depends on fcm_pkg and the fcm_in_if / fcm_out_if channel interfaces of the RTL.
`timescale 1ns / 1ps

module frontlight_color_mixer_tb;
  import fcm_pkg::*;

  // Run control. A quiet stretch much longer than a request's trip through the block
  // plus the longest stall means it has hung.
  localparam int QUIET_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 40;
  localparam int MAX_REPORTS   = 10;
  localparam int MAX_WAIT      = 9;
  localparam int RANDOM_PHASES = 19;
  localparam int PHASE_ITEMS   = 50;

  // Channel gains and offsets of the rgb formulas.
  localparam int W_SCALE     = 25;
  localparam int R_SCALE     = 24;
  localparam int WHITE_DROP  = 25;
  localparam int GREEN_DROP  = 65;
  localparam int LEVEL_TOP   = 255;

  localparam logic signed [REQ_W-1:0] REQ_MIN = 16'sh8000;
  localparam logic signed [REQ_W-1:0] REQ_MAX = 16'sh7FFF;

  // Index just past the register map: writes there must change nothing.
  localparam logic [2:0] UNMAPPED_REG = 3'd7;

  typedef struct packed {
    logic [1:0]         target;
    logic [LEVEL_W-1:0] plain;
    logic [LEVEL_W-1:0] white;
    logic [LEVEL_W-1:0] red;
    logic [LEVEL_W-1:0] green;
    logic [LEVEL_W-1:0] mixer;
    logic [3:0]         wmask;
    logic [2:0]         pmask;
  } light_setting_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  fcm_in_if  req_ch();
  fcm_out_if res_ch();

  frontlight_color_mixer u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (req_ch),
    .out_ch  (res_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Our own copy of the register file, updated on every write we issue.
  cfg_t           shadow_cfg;
  light_setting_t pending_settings[$];

  int tx_gap_max       = MAX_WAIT;
  int rx_stall_max     = MAX_WAIT;
  int fault_count      = 0;
  int requests_sent    = 0;
  int settings_checked = 0;
  int register_reads   = 0;
  int quiet_cycles     = 0;
  int mode_count[4]    = '{0, 0, 0, 0};

  always #10 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  function automatic int clamp_to(int v, int lo, int hi);
    // Upper bound first, so a crossed range settles on the lower bound.
    if (v > hi) v = hi;
    if (v < lo) v = lo;
    return v;
  endfunction

  function automatic logic [LEVEL_W-1:0] sat_level(int v);
    if (v < 0) return '0;
    if (v > LEVEL_TOP) return LEVEL_W'(LEVEL_TOP);
    return LEVEL_W'(v);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned root;
    longint unsigned trial;
    root = 0;
    for (int i = 31; i >= 0; i--) begin
      trial = root | (64'd1 << i);
      if (trial * trial <= n) root = trial;
    end
    return root;
  endfunction

  // floor(gain * product^(1/4)), taken exactly on gain^4 * product.
  // A negative product counts as zero.
  function automatic int gained_root4(int gain, int product);
    longint unsigned g;
    longint unsigned p;
    g = longint'(gain);
    p = (product > 0) ? longint'(product) : 0;
    return int'(int_sqrt(int_sqrt(g * g * g * g * p)));
  endfunction

  function automatic light_setting_t predict_light_setting(cfg_t c,
                                                           logic signed [REQ_W-1:0] lvl_req,
                                                           logic signed [REQ_W-1:0] tmp_req);
    light_setting_t s;
    int b;
    int t;
    int r;
    s = '0;
    b = clamp_to(int'(lvl_req), int'(c.level_min), int'(c.level_max));
    t = clamp_to(int'(tmp_req), int'(c.temp_min), int'(c.temp_max));
    if (c.temp_inverted) t = int'(c.temp_max) - t;
    s.target = c.light_mode;
    case (c.light_mode)
      MODE_PLAIN: begin
        s.plain = b[LEVEL_W-1:0];
      end
      MODE_MIXER: begin
        // Inverted crossed temperature bounds can go negative; saturate to zero.
        s.white = sat_level(b);
        s.mixer = sat_level(t);
        s.wmask = c.channel_present & MASK_MIXER;
      end
      MODE_RGB: begin
        if (b > 0)
          s.white = sat_level(gained_root4(W_SCALE, b * (int'(c.temp_max) - t)) - WHITE_DROP);
        if (t > 0) begin
          r = gained_root4(R_SCALE, b * t);
          s.red   = sat_level(r);
          s.green = sat_level(r - GREEN_DROP);
        end
        s.wmask = c.channel_present & MASK_RGB;
        // Power follows the level, regardless of channel presence.
        s.pmask = {s.green != '0, s.red != '0, s.white != '0};
      end
      default: ;
    endcase
    return s;
  endfunction

  function automatic string show_setting(light_setting_t s);
    return $sformatf("tgt=%0d plain=%0d w=%0d r=%0d g=%0d mix=%0d wm=%h pm=%h",
                     s.target, s.plain, s.white, s.red, s.green, s.mixer, s.wmask, s.pmask);
  endfunction

  function automatic void note_failure(string msg);
    fault_count++;
    if (fault_count <= MAX_REPORTS) $display("ERROR @%0t: %s", $realtime, msg);
  endfunction

  // ---------------------------------------------------------------------------
  // Register access over the config port
  // ---------------------------------------------------------------------------

  function automatic logic [CFG_DATA_W-1:0] register_value(logic [2:0] idx);
    case (idx)
      REG_LIGHT_MODE:      return CFG_DATA_W'(shadow_cfg.light_mode);
      REG_TEMP_INVERTED:   return CFG_DATA_W'(shadow_cfg.temp_inverted);
      REG_CHANNEL_PRESENT: return CFG_DATA_W'(shadow_cfg.channel_present);
      REG_LEVEL_MIN:       return CFG_DATA_W'(shadow_cfg.level_min);
      REG_LEVEL_MAX:       return CFG_DATA_W'(shadow_cfg.level_max);
      REG_TEMP_MIN:        return CFG_DATA_W'(shadow_cfg.temp_min);
      REG_TEMP_MAX:        return CFG_DATA_W'(shadow_cfg.temp_max);
      default:             return '0;
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] register_mask(logic [2:0] idx);
    case (idx)
      REG_LIGHT_MODE:      return CFG_DATA_W'(2'b11);
      REG_TEMP_INVERTED:   return CFG_DATA_W'(1'b1);
      REG_CHANNEL_PRESENT: return CFG_DATA_W'(4'hF);
      default:             return CFG_DATA_W'(8'hFF);
    endcase
  endfunction

  // Setup cycle, access cycle, then the bus idles so back-to-back calls
  // never assign psel twice in one step.
  task automatic write_register(input logic [2:0] idx, input logic [CFG_DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_LIGHT_MODE:      shadow_cfg.light_mode      = value[1:0];
      REG_TEMP_INVERTED:   shadow_cfg.temp_inverted   = value[0];
      REG_CHANNEL_PRESENT: shadow_cfg.channel_present = value[3:0];
      REG_LEVEL_MIN:       shadow_cfg.level_min       = value[7:0];
      REG_LEVEL_MAX:       shadow_cfg.level_max       = value[7:0];
      REG_TEMP_MIN:        shadow_cfg.temp_min        = value[7:0];
      REG_TEMP_MAX:        shadow_cfg.temp_max        = value[7:0];
      default: ;  // outside the map: no register changes
    endcase
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_register(input logic [2:0] idx);
    logic [CFG_DATA_W-1:0] data;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    data = prdata;
    register_reads++;
    if ((data & register_mask(idx)) !== register_value(idx))
      note_failure($sformatf("register %0d read %h, want %h", idx,
                             data & register_mask(idx), register_value(idx)));
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_all_registers();
    for (int i = 0; i <= int'(REG_TEMP_MAX); i++) check_register(3'(i));
  endtask

  task automatic apply_config(input logic [1:0] mode, input logic inv, input logic [3:0] present,
                              input logic [7:0] lmin, input logic [7:0] lmax,
                              input logic [7:0] tmin, input logic [7:0] tmax);
    write_register(REG_LIGHT_MODE, CFG_DATA_W'(mode));
    write_register(REG_TEMP_INVERTED, CFG_DATA_W'(inv));
    write_register(REG_CHANNEL_PRESENT, CFG_DATA_W'(present));
    write_register(REG_LEVEL_MIN, CFG_DATA_W'(lmin));
    write_register(REG_LEVEL_MAX, CFG_DATA_W'(lmax));
    write_register(REG_TEMP_MIN, CFG_DATA_W'(tmin));
    write_register(REG_TEMP_MAX, CFG_DATA_W'(tmax));
  endtask

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------

  // Called at a rising edge. Hold valid low for a random gap, then present the
  // request and wait for its transfer. Valid stays high on return so a zero gap
  // on the next call gives back-to-back transfers.
  task automatic send_request(input logic signed [REQ_W-1:0] lvl,
                              input logic signed [REQ_W-1:0] tmp);
    int gap;
    gap = $urandom_range(0, tx_gap_max);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid         <= 1'b1;
    req_ch.level_request <= lvl;
    req_ch.temp_request  <= tmp;
    do @(posedge clk); while (!req_ch.ready);
    pending_settings.push_back(predict_light_setting(shadow_cfg, lvl, tmp));
    requests_sent++;
    mode_count[shadow_cfg.light_mode]++;
  endtask

  // Drop valid and wait until every predicted setting has come back. Every
  // request gives exactly one result, so the block is idle afterwards.
  task automatic drain_results();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_settings.size() != 0);
  endtask

  // Mostly values around the configured range, plus raw 16-bit noise and corners.
  function automatic logic signed [REQ_W-1:0] pick_request(int lo, int hi);
    int a;
    int z;
    a = ((lo < hi) ? lo : hi) - 4;
    z = ((lo < hi) ? hi : lo) + 4;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return REQ_W'(a + int'($urandom_range(0, z - a)));
      5, 6, 7:       return REQ_W'($urandom);
      8: begin
        case ($urandom_range(0, 3))
          0:       return REQ_MIN;
          1:       return REQ_MAX;
          2:       return -1;
          default: return 0;
        endcase
      end
      default:       return REQ_W'($urandom_range(0, 1) ? lo : hi);
    endcase
  endfunction

  function automatic logic [7:0] pick_bound();
    case ($urandom_range(0, 5))
      0:       return 8'd0;
      1:       return 8'd255;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Result side
  // ---------------------------------------------------------------------------

  // Ready drops for a random number of cycles after each transfer.
  initial begin : result_sink
    int rx_wait;
    rx_wait = 0;
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (res_ch.valid && res_ch.ready) rx_wait = $urandom_range(0, rx_stall_max);
      if (rx_wait > 0) begin
        rx_wait--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  // Compare each result transfer with the oldest prediction, field by field.
  always @(posedge clk) begin : result_check
    light_setting_t got;
    light_setting_t want;
    logic [7:0]     bad;
    if (rst_n && res_ch.valid && res_ch.ready) begin
      got = '{target: res_ch.target, plain: res_ch.plain_level, white: res_ch.white_level,
              red: res_ch.red_level, green: res_ch.green_level, mixer: res_ch.mixer_level,
              wmask: res_ch.write_mask, pmask: res_ch.power_mask};
      if (pending_settings.size() == 0) begin
        note_failure($sformatf("result with nothing pending: %s", show_setting(got)));
      end else begin
        want = pending_settings.pop_front();
        bad = {got.target !== want.target, got.plain !== want.plain,
               got.white !== want.white, got.red !== want.red,
               got.green !== want.green, got.mixer !== want.mixer,
               got.wmask !== want.wmask, got.pmask !== want.pmask};
        if (bad != '0)
          note_failure($sformatf("result %0d fields %b (tgt,plain,w,r,g,mix,wm,pm)\n  want %s\n  got  %s",
                                 settings_checked, bad, show_setting(want), show_setting(got)));
      end
      settings_checked++;
    end
  end

  // Watchdog: any transfer or bus access counts as progress.
  always @(posedge clk) begin
    if (!rst_n || psel || (req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Watchdog: %0d cycles without a transfer, %0d results outstanding",
               QUIET_LIMIT, pending_settings.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset leaves the light off: every request gives an all-zero setting.
  task automatic test_reset_defaults();
    send_request(REQ_MAX, REQ_MAX);
    send_request(REQ_MIN, REQ_MIN);
    drain_results();
  endtask

  // Read back reset values, then all-ones, all-zeros and random patterns.
  // A write past the end of the map must leave every register alone.
  task automatic test_register_access();
    logic [CFG_DATA_W-1:0] patterns[3];
    patterns = '{32'hFFFF_FFFF, 32'h0000_0000, $urandom};
    check_all_registers();
    foreach (patterns[p]) begin
      for (int i = 0; i <= int'(REG_TEMP_MAX); i++) write_register(3'(i), patterns[p]);
      check_all_registers();
    end
    write_register(UNMAPPED_REG, 32'hFFFF_FFFF);
    check_all_registers();
  endtask

  // Plain level: clamp at both ends, full-scale requests, then crossed bounds.
  task automatic test_plain_mode();
    apply_config(MODE_PLAIN, 1'b0, 4'hF, 8'd20, 8'd200, 8'd0, 8'd255);
    send_request(REQ_MIN, REQ_MAX);
    send_request(REQ_MAX, REQ_MIN);
    send_request(19, 0);
    send_request(200, 0);
    send_request(-1, -1);
    drain_results();
    // Crossed level bounds: the minimum wins.
    apply_config(MODE_PLAIN, 1'b0, 4'hF, 8'd200, 8'd20, 8'd0, 8'd255);
    send_request(100, 0);
    drain_results();
  endtask

  // Mixer pair: plain and inverted temperature, write gating by presence, and
  // a negative temperature from inverted crossed bounds.
  task automatic test_mixer_mode();
    apply_config(MODE_MIXER, 1'b0, 4'b1001, 8'd3, 8'd250, 8'd3, 8'd250);
    send_request(50, -5);
    send_request(255, REQ_MAX);
    drain_results();
    apply_config(MODE_MIXER, 1'b1, 4'b0110, 8'd0, 8'd255, 8'd0, 8'd255);
    send_request(10, 100);
    drain_results();
    apply_config(MODE_MIXER, 1'b1, 4'hF, 8'd0, 8'd255, 8'd200, 8'd100);
    send_request(10, 0);
    drain_results();
  endtask

  // Rgb: zero temperature, zero brightness, full-scale product, smallest
  // nonzero inputs, negative white product and power with no channel present.
  task automatic test_rgb_mode();
    apply_config(MODE_RGB, 1'b0, 4'hF, 8'd0, 8'd255, 8'd0, 8'd255);
    send_request(255, 0);
    send_request(0, 128);
    send_request(255, 255);
    send_request(255, 128);
    send_request(1, 1);
    drain_results();
    // Temperature clamps above temp_max, so the white product goes negative.
    apply_config(MODE_RGB, 1'b0, 4'hF, 8'd0, 8'd255, 8'd200, 8'd100);
    send_request(100, 0);
    drain_results();
    apply_config(MODE_RGB, 1'b1, 4'h0, 8'd0, 8'd255, 8'd0, 8'd255);
    send_request(200, 55);
    send_request(REQ_MAX, REQ_MIN);
    drain_results();
  endtask

  // Random phases: a fresh config and pacing each phase, then a burst of
  // requests. Each phase ends with a full drain before the config changes.
  task automatic test_random_traffic();
    logic [1:0] mode;
    logic [7:0] lmin;
    logic [7:0] lmax;
    logic [7:0] tmin;
    logic [7:0] tmax;
    logic [7:0] swap;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0: apply_config(MODE_RGB, 1'b0, 4'hF, 8'd0, 8'd255, 8'd0, 8'd255);
        1: apply_config(MODE_RGB, 1'b1, 4'hF, 8'd255, 8'd0, 8'd255, 8'd0);
        2: apply_config(MODE_MIXER, 1'b1, 4'hF, 8'd0, 8'd255, 8'd0, 8'd255);
        default: begin
          case ($urandom_range(0, 7))
            0:       mode = MODE_OFF;
            1, 2:    mode = MODE_PLAIN;
            3, 4:    mode = MODE_MIXER;
            default: mode = MODE_RGB;
          endcase
          lmin = pick_bound();
          lmax = pick_bound();
          tmin = pick_bound();
          tmax = pick_bound();
          // Keep most ranges ordered; leave some crossed.
          if (lmin > lmax && $urandom_range(0, 4) != 0) begin
            swap = lmin; lmin = lmax; lmax = swap;
          end
          if (tmin > tmax && $urandom_range(0, 4) != 0) begin
            swap = tmin; tmin = tmax; tmax = swap;
          end
          apply_config(mode, 1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)),
                       lmin, lmax, tmin, tmax);
        end
      endcase
      // Pacing: no idling, sender gaps only, receiver stalls only, or both.
      case ($urandom_range(0, 3))
        0:       begin tx_gap_max = 0;        rx_stall_max = 0;        end
        1:       begin tx_gap_max = MAX_WAIT; rx_stall_max = 0;        end
        2:       begin tx_gap_max = 0;        rx_stall_max = MAX_WAIT; end
        default: begin tx_gap_max = MAX_WAIT; rx_stall_max = MAX_WAIT; end
      endcase
      repeat (PHASE_ITEMS)
        send_request(pick_request(int'(shadow_cfg.level_min), int'(shadow_cfg.level_max)),
                     pick_request(int'(shadow_cfg.temp_min), int'(shadow_cfg.temp_max)));
      drain_results();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    shadow_cfg = '{light_mode: MODE_OFF, temp_inverted: 1'b0, channel_present: 4'd0,
                   level_min: 8'd0, level_max: 8'd100, temp_min: 8'd0, temp_max: 8'd10};
    rst_n                <= 1'b0;
    psel                 <= 1'b0;
    penable              <= 1'b0;
    pwrite               <= 1'b0;
    paddr                <= '0;
    pwdata               <= '0;
    req_ch.valid         <= 1'b0;
    req_ch.level_request <= '0;
    req_ch.temp_request  <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_register_access();
    test_plain_mode();
    test_mixer_mode();
    test_rgb_mode();
    test_random_traffic();

    // Let anything stray come out of the pipeline before judging the run.
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Run: %0d requests (off %0d, plain %0d, mixer %0d, rgb %0d), %0d random phases,",
             requests_sent, mode_count[MODE_OFF], mode_count[MODE_PLAIN],
             mode_count[MODE_MIXER], mode_count[MODE_RGB], RANDOM_PHASES);
    $display("     %0d results checked, %0d register reads, %0d failures.",
             settings_checked, register_reads, fault_count);
    if (fault_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/fcm_pkg.sv
rtl/fcm_if.sv
rtl/fcm_front.sv
rtl/fcm_queue.sv
rtl/fcm_isqrt.sv
rtl/fcm_back.sv
rtl/frontlight_color_mixer.sv
sim/frontlight_color_mixer_tb.sv
